// ----- rtl/zoomed_sprite_line_renderer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the zoomed sprite line renderer
// Overlapping and next-cycle implication checks that compile away when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ZOOMED_SPRITE_LINE_RENDERER_CORE_DEFINES_SVH
`define ZOOMED_SPRITE_LINE_RENDERER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ZSLR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zslr assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ZSLR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zslr assertion failed");
`else
`define ZSLR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ZSLR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/zslr_pkg.sv -----
// ----------------------------------------------------------------------------
// Zoomed sprite line renderer package
// Field widths, result kinds and the record passed from the pixel unit.
// ----------------------------------------------------------------------------
package zslr_pkg;

  localparam int WORD_W  = 16;
  localparam int ORIGIN_W = 9;
  localparam int PIXX_W  = 9;
  localparam int PIXY_W  = 8;
  localparam int FETCH_W = 18;
  localparam int KIND_W  = 2;
  localparam int COL_W   = 11;
  localparam int HACC_W  = 7;
  localparam int ZOOM_W  = 5;

  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 9'd184;
  // A row ends once more than this many pixels have been kept.
  localparam logic [COL_W-1:0]    ROW_PIXEL_LIMIT = 11'h200;
  localparam logic [3:0]          PEN_CLEAR = 4'h0;
  localparam logic [3:0]          PEN_STOP  = 4'hf;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_END   = 2'd3
  } zslr_kind_t;

  typedef struct packed {
    logic [HACC_W-1:0] horiz_accum_next;
    logic              kept;
    logic              write;
    logic [3:0]        pix;
    logic [PIXX_W-1:0] x;
    logic [COL_W-1:0]  cur_column_next;
  } zslr_pix_res_t;

endpackage

// ----- rtl/zslr_channels.sv -----
// ----------------------------------------------------------------------------
// Zoomed sprite line renderer channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface zslr_item_if;
  import zslr_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [WORD_W-1:0] entry_word0;
  logic [WORD_W-1:0] entry_word1;
  logic [WORD_W-1:0] entry_word2;
  logic [WORD_W-1:0] entry_word3;
  logic [WORD_W-1:0] entry_word4;
  logic [WORD_W-1:0] entry_word5;
  logic [WORD_W-1:0] rom_data;

  modport source (
    output valid, action, entry_word0, entry_word1, entry_word2, entry_word3,
           entry_word4, entry_word5, rom_data,
    input  ready
  );
  modport sink (
    input  valid, action, entry_word0, entry_word1, entry_word2, entry_word3,
           entry_word4, entry_word5, rom_data,
    output ready
  );
endinterface

interface zslr_result_if;
  import zslr_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [PIXX_W-1:0]  pixel_x;
  logic [PIXY_W-1:0]  pixel_y;
  logic [WORD_W-1:0]  pen;
  logic [FETCH_W-1:0] fetch_address;
  logic               last;

  modport source (
    output valid, kind, pixel_x, pixel_y, pen, fetch_address, last,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_x, pixel_y, pen, fetch_address, last,
    output ready
  );
endinterface

interface zslr_cfg_if;
  import zslr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ORIGIN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/zslr_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// Zoomed sprite line renderer pixel unit
// One nibble per use: horizontal zoom step, column advance and clipping.
// ----------------------------------------------------------------------------
module zslr_pixel_unit #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic [zslr_pkg::WORD_W-1:0]  data,
  input  logic [1:0]                   nib,
  input  logic                         mirror,
  input  logic [zslr_pkg::HACC_W-1:0]  horiz_accum,
  input  logic [zslr_pkg::ZOOM_W-1:0]  horiz_zoom,
  input  logic [zslr_pkg::COL_W-1:0]   start_column,
  input  logic [zslr_pkg::COL_W-1:0]   cur_column,
  output zslr_pkg::zslr_pix_res_t      res
);
  import zslr_pkg::*;

  localparam int XW = COL_W + 1;
  localparam logic signed [XW-1:0] X_LIMIT = XW'(SCREEN_WIDTH);

  logic [1:0]              sel;
  logic [3:0]              pix;
  logic [HACC_W-1:0]       acc;
  logic signed [XW-1:0]    x;
  logic                    on_screen;

  always_comb begin
    // Unmirrored words give their first pixel from the top nibble.
    sel = mirror ? nib : ~nib;
    pix = data[{sel, 2'b00} +: 4];
    acc = {1'b0, horiz_accum[HACC_W-2:0]} + {2'b00, horiz_zoom};
    x = $signed({start_column[COL_W-1], start_column}) + $signed({1'b0, cur_column});
    on_screen = !x[XW-1] && (x < X_LIMIT);

    res.horiz_accum_next = acc;
    res.kept             = !acc[HACC_W-1];
    res.pix              = pix;
    res.write            = res.kept && (pix != PEN_CLEAR) && (pix != PEN_STOP) && on_screen;
    res.x                = x[PIXX_W-1:0];
    res.cur_column_next  = cur_column + {{(COL_W-1){1'b0}}, res.kept};
  end

endmodule

// ----- rtl/zoomed_sprite_line_renderer_core.sv -----
// ----------------------------------------------------------------------------
// Zoomed sprite line renderer core
// Decodes sprite entries, walks zoomed rows and turns graphics ROM words
// into pixel writes and ROM fetch requests.
//
// A request on sprite_in is either a six-word sprite entry or the ROM word
// answering the last fetch request. Every entry produces exactly one result:
// end of list, sprite finished, or the first ROM fetch request of the first
// visible row. Every ROM word produces up to four pixel writes followed by
// one fetch request or a sprite finished result; the final result of each
// request carries last. A ROM word that arrives while no sprite is in
// progress is taken and dropped. All work goes through a small sequencer.
// An entry goes through accept, one row step and result, or only accept and
// result when it is the end of the list, hidden or empty. A ROM word goes
// through accept, four nibbles, a row step if it ends a row, and result. The
// single pixel unit handles one nibble per cycle while the result register
// has room, the row step unit one row per cycle. Each stage that produces a
// result holds while the one-entry result register is still occupied.
// sprite_in is ready only while the sequencer waits. x_offset resets to 184.
// Users must write it through cfg only while the core is idle (unenforced).
// ----------------------------------------------------------------------------
`include "zoomed_sprite_line_renderer_core_defines.svh"

module zoomed_sprite_line_renderer_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 224,
  parameter int ROM_WORD_BITS = 18
) (
  input  logic          clk,
  input  logic          rst,
  zslr_item_if.sink     sprite_in,
  zslr_result_if.source result_out,
  zslr_cfg_if.sink      cfg
);
  import zslr_pkg::*;

  localparam int WIDE_W = ROM_WORD_BITS + FETCH_W;
  localparam logic [PIXY_W:0] ROW_LIMIT = (PIXY_W + 1)'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_SEEK,
    ST_PIX,
    ST_FETCH,
    ST_RESULT
  } state_t;

  state_t state;

  // Configuration and sprite state.
  logic [ORIGIN_W-1:0]      x_offset;
  logic                     active;
  logic [PIXY_W-1:0]        row;
  logic [PIXY_W-1:0]        scan_row;
  logic [PIXY_W-1:0]        bottom_row;
  logic [WORD_W-1:0]        row_address;
  logic [7:0]               pitch;
  logic                     mirror;
  logic [1:0]               bank_sel;
  logic [WORD_W-1:0]        colour_base;
  logic [ZOOM_W-1:0]        vert_zoom;
  logic [ZOOM_W-1:0]        horiz_zoom;
  logic [WORD_W-1:0]        vert_accum;
  logic [HACC_W-1:0]        horiz_accum;
  logic [COL_W-1:0]         start_column;
  logic [COL_W-1:0]         cur_column;
  logic [ROM_WORD_BITS-1:0] word_pointer;
  logic [WORD_W-1:0]        rom_word;
  logic [1:0]               nib;
  zslr_kind_t               res_kind;

  // Result register.
  logic                     out_valid;
  logic [KIND_W-1:0]        out_kind;
  logic [PIXX_W-1:0]        out_x;
  logic [PIXY_W-1:0]        out_y;
  logic [WORD_W-1:0]        out_pen;
  logic [FETCH_W-1:0]       out_addr;
  logic                     out_last;

  logic                     slot_free;
  logic                     out_load;
  logic                     in_accept;
  zslr_pix_res_t            pres;

  // Row step unit and decode signals.
  logic [WORD_W-1:0]        step;
  logic [WORD_W-1:0]        vsum;
  logic [WORD_W-1:0]        row_address_next;
  logic [WORD_W-1:0]        vert_accum_next;
  logic [WIDE_W-1:0]        base_wide;
  logic [WIDE_W-1:0]        wp_wide;
  logic                     row_visible;
  logic                     row_end;
  logic [ROM_WORD_BITS-1:0] wp_step;

  assign slot_free       = !out_valid || result_out.ready;
  assign sprite_in.ready = (state == ST_WAIT);
  assign in_accept       = sprite_in.valid && sprite_in.ready;
  assign cfg.ready       = 1'b1;

  // The result register is loaded by a pixel write, a fetch request or a
  // single closing result, always only when it has room.
  assign out_load = slot_free && (((state == ST_PIX) && pres.write) ||
                                  (state == ST_FETCH) || (state == ST_RESULT));

  assign result_out.valid         = out_valid;
  assign result_out.kind          = out_kind;
  assign result_out.pixel_x       = out_x;
  assign result_out.pixel_y       = out_y;
  assign result_out.pen           = out_pen;
  assign result_out.fetch_address = out_addr;
  assign result_out.last          = out_last;

  zslr_pixel_unit #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_pixel (
    .data         (rom_word),
    .nib          (nib),
    .mirror       (mirror),
    .horiz_accum  (horiz_accum),
    .horiz_zoom   (horiz_zoom),
    .start_column (start_column),
    .cur_column   (cur_column),
    .res          (pres)
  );

  always_comb begin
    // One row of the vertical walk: the address gains the signed pitch, and
    // once more when the vertical accumulator overflows into bit 15.
    step = {{(WORD_W-8){pitch[7]}}, pitch};
    vsum = vert_accum + {1'b0, vert_zoom, 10'b0};
    if (vsum[WORD_W-1]) begin
      row_address_next = row_address + {step[WORD_W-2:0], 1'b0};
      vert_accum_next  = {1'b0, vsum[WORD_W-2:0]};
    end else begin
      row_address_next = row_address + step;
      vert_accum_next  = vsum;
    end
    base_wide = {{ROM_WORD_BITS{1'b0}}, bank_sel, row_address_next};
    wp_wide   = {{FETCH_W{1'b0}}, word_pointer};
    // Rows past the screen bottom never come back, so the walk stops there.
    row_visible = (scan_row < bottom_row) && ({1'b0, scan_row} < ROW_LIMIT);
    row_end     = (pres.pix == PEN_STOP) || (pres.cur_column_next > ROW_PIXEL_LIMIT);
    wp_step     = mirror ? word_pointer - ROM_WORD_BITS'(1)
                         : word_pointer + ROM_WORD_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      active    <= 1'b0;
      out_valid <= 1'b0;
      x_offset  <= ORIGIN_RESET;
    end else begin
      if (cfg.valid) begin
        x_offset <= cfg.data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_WAIT: begin
          if (in_accept && !sprite_in.action) begin
            active <= 1'b0;
            if (sprite_in.entry_word2[15]) begin
              res_kind <= KIND_END;
              state    <= ST_RESULT;
            end else if (sprite_in.entry_word2[14] ||
                         (sprite_in.entry_word0[7:0] >= sprite_in.entry_word0[15:8])) begin
              res_kind <= KIND_DONE;
              state    <= ST_RESULT;
            end else begin
              scan_row     <= sprite_in.entry_word0[7:0];
              bottom_row   <= sprite_in.entry_word0[15:8];
              start_column <= {2'b00, sprite_in.entry_word1[8:0]} - {2'b00, x_offset};
              mirror       <= sprite_in.entry_word2[8];
              pitch        <= sprite_in.entry_word2[7:0];
              row_address  <= sprite_in.entry_word3;
              bank_sel     <= sprite_in.entry_word4[9:8];
              colour_base  <= {sprite_in.entry_word1[12:9], sprite_in.entry_word4[7:0], 4'b0};
              vert_zoom    <= sprite_in.entry_word5[9:5];
              horiz_zoom   <= sprite_in.entry_word5[4:0];
              vert_accum   <= {6'b0, sprite_in.entry_word5[9:0]};
              state        <= ST_SEEK;
            end
          end else if (in_accept && active) begin
            rom_word <= sprite_in.rom_data;
            nib      <= 2'd0;
            state    <= ST_PIX;
          end
        end

        ST_SEEK: begin
          if (row_visible) begin
            row_address  <= row_address_next;
            vert_accum   <= vert_accum_next;
            row          <= scan_row;
            horiz_accum  <= {horiz_zoom, 2'b00};
            cur_column   <= '0;
            word_pointer <= base_wide[ROM_WORD_BITS-1:0];
            active       <= 1'b1;
            state        <= ST_FETCH;
          end else begin
            active   <= 1'b0;
            res_kind <= KIND_DONE;
            state    <= ST_RESULT;
          end
        end

        ST_PIX: begin
          if (slot_free) begin
            horiz_accum <= pres.horiz_accum_next;
            cur_column  <= pres.cur_column_next;
            if (pres.write) begin
              out_kind  <= KIND_PIXEL;
              out_x     <= pres.x;
              out_y     <= row;
              out_pen   <= colour_base | {12'b0, pres.pix};
              out_addr  <= '0;
              out_last  <= 1'b0;
            end
            nib <= nib + 2'd1;
            if (nib == 2'd3) begin
              if (row_end) begin
                scan_row <= row + 8'd1;
                state    <= ST_SEEK;
              end else begin
                word_pointer <= wp_step;
                state        <= ST_FETCH;
              end
            end
          end
        end

        ST_FETCH: begin
          if (slot_free) begin
            out_kind  <= KIND_FETCH;
            out_x     <= '0;
            out_y     <= row;
            out_pen   <= '0;
            out_addr  <= wp_wide[FETCH_W-1:0];
            out_last  <= 1'b1;
            state     <= ST_WAIT;
          end
        end

        ST_RESULT: begin
          if (slot_free) begin
            out_kind  <= res_kind;
            out_x     <= '0;
            out_y     <= '0;
            out_pen   <= '0;
            out_addr  <= '0;
            out_last  <= 1'b1;
            state     <= ST_WAIT;
          end
        end

        default: begin
          state <= ST_WAIT;
        end
      endcase
    end
  end

  // A pixel write is never the closing result of a request.
  `ZSLR_ASSERT_IMP(a_pixel_not_last, clk, rst,
    result_out.valid && (result_out.kind == KIND_PIXEL), !result_out.last)

  // A ROM word taken for a sprite in progress always starts the nibble walk.
  `ZSLR_ASSERT_NXT(a_rom_word_starts_pixels, clk, rst,
    in_accept && sprite_in.action && active, state == ST_PIX)

  // Pixel writes only land inside the screen.
  `ZSLR_ASSERT_IMP(a_pixel_on_screen, clk, rst,
    result_out.valid && (result_out.kind == KIND_PIXEL),
    {2'b00, result_out.pixel_x} < 11'(SCREEN_WIDTH))

endmodule

// ----- verif/sprite_render_checker.sv -----
// ----------------------------------------------------------------------------
// Sprite render checker
// Watches the request, result and origin channels of the zoomed sprite line
// renderer, predicts the results of every accepted request and compares them
// in order with what the core delivers.
// ----------------------------------------------------------------------------
module sprite_render_checker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 224,
  parameter int ROM_WORD_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  logic                          action,
  input  logic [zslr_pkg::WORD_W-1:0]   entry_word0,
  input  logic [zslr_pkg::WORD_W-1:0]   entry_word1,
  input  logic [zslr_pkg::WORD_W-1:0]   entry_word2,
  input  logic [zslr_pkg::WORD_W-1:0]   entry_word3,
  input  logic [zslr_pkg::WORD_W-1:0]   entry_word4,
  input  logic [zslr_pkg::WORD_W-1:0]   entry_word5,
  input  logic [zslr_pkg::WORD_W-1:0]   rom_data,
  input  logic                          res_valid,
  input  logic                          res_ready,
  input  logic [zslr_pkg::KIND_W-1:0]   kind,
  input  logic [zslr_pkg::PIXX_W-1:0]   pixel_x,
  input  logic [zslr_pkg::PIXY_W-1:0]   pixel_y,
  input  logic [zslr_pkg::WORD_W-1:0]   pen,
  input  logic [zslr_pkg::FETCH_W-1:0]  fetch_address,
  input  logic                          last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [zslr_pkg::ORIGIN_W-1:0] cfg_data,
  output int                            failures,
  output int                            pending,
  output int                            checked
);
  import zslr_pkg::*;

  localparam logic [31:0] ROM_MASK = (32'd1 << ROM_WORD_BITS) - 32'd1;

  typedef struct packed {
    zslr_kind_t         kind;
    logic [PIXX_W-1:0]  x;
    logic [PIXY_W-1:0]  y;
    logic [WORD_W-1:0]  pen;
    logic [FETCH_W-1:0] addr;
    logic               last;
  } render_result_t;

  // Own copy of the renderer state.
  logic [ORIGIN_W-1:0] origin;
  logic                drawing;
  logic [7:0]          cur_row;
  logic [7:0]          end_row;
  logic [15:0]         line_addr;
  logic [7:0]          pitch;
  logic                flip;
  logic [1:0]          bank;
  logic [15:0]         colour;
  logic [ZOOM_W-1:0]   vzoom;
  logic [ZOOM_W-1:0]   hzoom;
  logic [15:0]         vacc;
  logic [HACC_W-1:0]   hacc;
  int                  start_col;
  logic [COL_W-1:0]    kept;
  logic [FETCH_W-1:0]  word_addr;

  render_result_t render_queue[$];
  render_result_t step_out[$];
  int             fail_count;
  int             result_count;

  function automatic void add_result(zslr_kind_t k, logic [PIXX_W-1:0] x,
                                     logic [PIXY_W-1:0] y, logic [WORD_W-1:0] p,
                                     logic [FETCH_W-1:0] a);
    render_result_t r;
    r.kind = k;
    r.x    = x;
    r.y    = y;
    r.pen  = p;
    r.addr = a;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // Advances the vertical walk to the next row that lies on screen.
  function automatic bit seek_row(int y);
    logic [15:0] step;
    step = {{8{pitch[7]}}, pitch};
    while (y < int'(end_row)) begin
      line_addr = line_addr + step;
      vacc = vacc + (16'(vzoom) << 10);
      if (vacc[15]) begin
        line_addr = line_addr + step;
        vacc[15]  = 1'b0;
      end
      if (y < SCREEN_HEIGHT) begin
        cur_row   = y[7:0];
        hacc      = {hzoom, 2'b00};
        kept      = '0;
        word_addr = FETCH_W'(((32'(bank) << 16) + 32'(line_addr)) & ROM_MASK);
        return 1'b1;
      end
      y++;
    end
    return 1'b0;
  endfunction

  function automatic void render_request(logic act, logic [15:0] w0, logic [15:0] w1,
                                         logic [15:0] w2, logic [15:0] w3,
                                         logic [15:0] w4, logic [15:0] w5,
                                         logic [15:0] data);
    logic [7:0] top;
    logic [3:0] pix;
    int         col;
    step_out.delete();
    if (!act) begin
      top     = w0[7:0];
      drawing = 1'b0;
      if (w2[15]) begin
        add_result(KIND_END, '0, '0, '0, '0);
      end else if (w2[14] || top >= w0[15:8]) begin
        add_result(KIND_DONE, '0, '0, '0, '0);
      end else begin
        end_row   = w0[15:8];
        start_col = int'(w1[8:0]) - int'(origin);
        flip      = w2[8];
        pitch     = w2[7:0];
        line_addr = w3;
        bank      = w4[9:8];
        colour    = {w1[12:9], w4[7:0], 4'h0};
        vzoom     = w5[9:5];
        hzoom     = w5[4:0];
        vacc      = {6'd0, w5[9:0]};
        if (seek_row(int'(top))) begin
          drawing = 1'b1;
          add_result(KIND_FETCH, '0, cur_row, '0, word_addr);
        end else begin
          add_result(KIND_DONE, '0, '0, '0, '0);
        end
      end
    end else if (drawing) begin
      pix = 4'h0;
      for (int i = 0; i < 4; i++) begin
        pix  = flip ? data[4*i +: 4] : data[12-4*i +: 4];
        hacc = (hacc & 7'h3f) + 7'(hzoom);
        if (hacc < 7'h40) begin
          col = start_col + int'(kept);
          if (pix != PEN_CLEAR && pix != PEN_STOP && col >= 0 && col < SCREEN_WIDTH)
            add_result(KIND_PIXEL, col[8:0], cur_row, colour | 16'(pix), '0);
          kept = kept + COL_W'(1);
        end
      end
      if (pix == PEN_STOP || kept > ROW_PIXEL_LIMIT) begin
        if (seek_row(int'(cur_row) + 1)) begin
          add_result(KIND_FETCH, '0, cur_row, '0, word_addr);
        end else begin
          drawing = 1'b0;
          add_result(KIND_DONE, '0, '0, '0, '0);
        end
      end else begin
        word_addr = FETCH_W'((flip ? 32'(word_addr) - 32'd1 : 32'(word_addr) + 32'd1)
                             & ROM_MASK);
        add_result(KIND_FETCH, '0, cur_row, '0, word_addr);
      end
    end
    if (step_out.size() > 0)
      step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i])
      render_queue.push_back(step_out[i]);
  endfunction

  always @(posedge clk) begin
    render_result_t got;
    render_result_t want;
    if (rst) begin
      origin    = ORIGIN_RESET;
      drawing   = 1'b0;
      cur_row   = '0;
      end_row   = '0;
      line_addr = '0;
      pitch     = '0;
      flip      = 1'b0;
      bank      = '0;
      colour    = '0;
      vzoom     = '0;
      hzoom     = '0;
      vacc      = '0;
      hacc      = '0;
      start_col = 0;
      kept      = '0;
      word_addr = '0;
      render_queue.delete();
    end else begin
      if (res_valid && res_ready) begin
        got.kind = zslr_kind_t'(kind);
        got.x    = pixel_x;
        got.y    = pixel_y;
        got.pen  = pen;
        got.addr = fetch_address;
        got.last = last;
        result_count++;
        if (render_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result kind %0d x %0d y %0d pen %h addr %h last %0d",
                   $time, got.kind, got.x, got.y, got.pen, got.addr, got.last);
        end else begin
          want = render_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected kind %0d x %0d y %0d pen %h addr %h last %0d",
                     $time, want.kind, want.x, want.y, want.pen, want.addr, want.last);
            $display("%0t:   actual kind %0d x %0d y %0d pen %h addr %h last %0d",
                     $time, got.kind, got.x, got.y, got.pen, got.addr, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        origin = cfg_data;
      if (item_valid && item_ready)
        render_request(action, entry_word0, entry_word1, entry_word2, entry_word3,
                       entry_word4, entry_word5, rom_data);
    end
    failures <= fail_count;
    pending  <= render_queue.size();
    checked  <= result_count;
  end

  initial begin
    fail_count   = 0;
    result_count = 0;
  end

endmodule

// ----- verif/zoomed_sprite_line_renderer_core_tb.sv -----
// ----------------------------------------------------------------------------
// Zoomed sprite line renderer core testbench
// Drives sprite entries and graphics ROM words into the core, applies random
// back-pressure on the result channel and lets the checker compare every
// result with its own prediction, across several x_offset settings.
// ----------------------------------------------------------------------------
module zoomed_sprite_line_renderer_core_tb;
  import zslr_pkg::*;

  // The timeout is far beyond the slowest legal run: even with every result
  // waiting out the longest receiver gap the whole run stays well below it.
  localparam int LIMIT_CYCLES = 500000;
  // Settling margin after the last result before the next configuration
  // write; the core is already waiting for a request by then.
  localparam int DRAIN_CYCLES = 24;
  // Length of the deliberate result stall.
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 16;
  localparam int PHASES       = 4;

  logic clk;
  logic rst;
  int   cycles;

  zslr_item_if   sprite_ch();
  zslr_result_if result_ch();
  zslr_cfg_if    cfg_ch();

  int fail_total;
  int pending_total;
  int results_checked;

  // Stimulus state; steady and hold_req are shared with the result receiver.
  bit            steady;
  bit            hold_req;
  logic [8:0]    origin_now;
  int            requests_sent;
  int            entries_sent;
  int            words_sent;
  int            settings_used;

  zoomed_sprite_line_renderer_core u_top (
    .clk        (clk),
    .rst        (rst),
    .sprite_in  (sprite_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  sprite_render_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (sprite_ch.valid),
    .item_ready    (sprite_ch.ready),
    .action        (sprite_ch.action),
    .entry_word0   (sprite_ch.entry_word0),
    .entry_word1   (sprite_ch.entry_word1),
    .entry_word2   (sprite_ch.entry_word2),
    .entry_word3   (sprite_ch.entry_word3),
    .entry_word4   (sprite_ch.entry_word4),
    .entry_word5   (sprite_ch.entry_word5),
    .rom_data      (sprite_ch.rom_data),
    .res_valid     (result_ch.valid),
    .res_ready     (result_ch.ready),
    .kind          (result_ch.kind),
    .pixel_x       (result_ch.pixel_x),
    .pixel_y       (result_ch.pixel_y),
    .pen           (result_ch.pen),
    .fetch_address (result_ch.fetch_address),
    .last          (result_ch.last),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_data      (cfg_ch.data),
    .failures      (fail_total),
    .pending       (pending_total),
    .checked       (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung core or a lost result ends the run here.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then a long one. In a steady
  // stretch no idle gap is picked for either side.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result receiver. ready toggles in stretches; when the stimulus asks for a
  // hold it stays low through the deliberate stall so that the core backs up.
  initial begin
    int n;
    result_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        result_ch.ready = 1'b1;
      end
      n = pick_gap();
      repeat (n) begin
        @(negedge clk);
        result_ch.ready = 1'b0;
      end
    end
  end

  // Offers one request after a random gap and returns at the rising edge at
  // which it was taken. valid is left high so that back-to-back requests do
  // not see it drop; whoever stops sending lowers it at the next falling edge.
  task automatic send_request(logic act, logic [15:0] w0, logic [15:0] w1,
                              logic [15:0] w2, logic [15:0] w3, logic [15:0] w4,
                              logic [15:0] w5, logic [15:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      sprite_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sprite_ch.valid       = 1'b1;
    sprite_ch.action      = act;
    sprite_ch.entry_word0 = w0;
    sprite_ch.entry_word1 = w1;
    sprite_ch.entry_word2 = w2;
    sprite_ch.entry_word3 = w3;
    sprite_ch.entry_word4 = w4;
    sprite_ch.entry_word5 = w5;
    sprite_ch.rom_data    = data;
    @(posedge clk);
    while (!sprite_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // A sprite entry request; the ROM word lane carries junk.
  task automatic send_entry(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                            logic [15:0] w3, logic [15:0] w4, logic [15:0] w5);
    send_request(1'b0, w0, w1, w2, w3, w4, w5, 16'($urandom));
    entries_sent++;
  endtask

  // A ROM word request; the entry lanes carry junk that must be ignored.
  task automatic send_rom(logic [15:0] data);
    send_request(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), data);
    words_sent++;
  endtask

  // Waits until every predicted result has been delivered, then lets the
  // core settle before anything else happens.
  task automatic wait_idle();
    @(negedge clk);
    sprite_ch.valid = 1'b0;
    @(posedge clk);
    while (pending_total != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_origin(logic [8:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    origin_now   = value;
    settings_used++;
  endtask

  // A ROM word that ends the row fairly often: the last nibble processed is
  // the low one normally and the high one when the sprite is flipped.
  function automatic logic [15:0] random_rom_word();
    logic [15:0] d;
    int          r;
    d = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 35)
      d[3:0] = PEN_STOP;
    else if (r < 50)
      d[15:12] = PEN_STOP;
    return d;
  endfunction

  // A sprite entry with random content. Most are short, visible sprites so
  // that rows actually get drawn; some sit at the bottom of the screen and
  // the rest are end-of-list, hidden or empty entries.
  task automatic send_random_sprite();
    logic [7:0]  top;
    logic [7:0]  bottom;
    logic [15:0] w1;
    logic [15:0] w2;
    int          pick;
    pick   = $urandom_range(0, 99);
    top    = 8'($urandom_range(0, 223));
    bottom = top + 8'($urandom_range(1, 4));
    if (pick < 10) begin
      top    = 8'($urandom_range(200, 254));
      bottom = 8'($urandom_range(int'(top) + 1, 255));
    end
    w2     = 16'($urandom);
    w2[15] = 1'b0;
    w2[14] = 1'b0;
    if (pick >= 90 && pick < 94)
      w2[15] = 1'b1;
    else if (pick >= 94 && pick < 97)
      w2[14] = 1'b1;
    else if (pick >= 97)
      bottom = 8'($urandom_range(0, int'(top)));
    w1 = 16'($urandom);
    if (pick < 80)
      w1[8:0] = origin_now + 9'($urandom_range(0, 340)) - 9'd16;
    send_entry({bottom, top}, w1, w2, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // One row with no horizontal zoom and no stop pen in a word's low nibble, so
  // that it runs until more than 512 pixels are kept; the last word is dropped.
  task automatic send_long_row();
    logic [15:0] d;
    logic [15:0] w1;
    w1      = 16'($urandom);
    w1[8:0] = origin_now + 9'd4;
    send_entry(16'h0B0A, w1, 16'h0000, 16'($urandom), 16'($urandom), 16'h0000);
    repeat (130) begin
      d = 16'($urandom);
      if (d[3:0] == PEN_STOP)
        d[3:0] = 4'h7;
      send_rom(d);
    end
  endtask

  initial begin
    int ph;
    int sent_here;
    int n;
    logic [8:0] phase_origin [PHASES];

    rst                   = 1'b1;
    steady                = 1'b0;
    hold_req              = 1'b0;
    origin_now            = ORIGIN_RESET;
    requests_sent         = 0;
    entries_sent          = 0;
    words_sent            = 0;
    settings_used         = 1;
    sprite_ch.valid       = 1'b0;
    sprite_ch.action      = 1'b0;
    sprite_ch.entry_word0 = '0;
    sprite_ch.entry_word1 = '0;
    sprite_ch.entry_word2 = '0;
    sprite_ch.entry_word3 = '0;
    sprite_ch.entry_word4 = '0;
    sprite_ch.entry_word5 = '0;
    sprite_ch.rom_data    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with x_offset at its reset value.
    // A ROM word before any sprite has started is taken and dropped.
    send_rom(16'hFFFF);
    // All ones: the end bit wins over hide and everything else.
    send_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // A hidden sprite, then empty ones with top equal to and above bottom.
    send_entry(16'h0A05, 16'h0100, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_entry(16'h0505, 16'h00B8, 16'h0000, 16'h1234, 16'h0000, 16'h0000);
    send_entry(16'h0306, 16'h00B8, 16'h0000, 16'h1234, 16'h0000, 16'h0000);
    // A sprite lying wholly below the screen has no visible row.
    send_entry(16'hF0E6, 16'h00C0, 16'h0001, 16'h0000, 16'h0100, 16'h0000);
    // A sprite crossing the bottom edge: four rows are drawn, the rest are
    // skipped and the last stop pen finishes the sprite.
    send_entry(16'hE6DC, 16'h14B8, 16'h0001, 16'h1000, 16'h0255, 16'h0000);
    send_rom(16'h1234);
    send_rom(16'h0F0F);
    send_rom(16'h89AF);
    send_rom(16'h000F);
    send_rom(16'hFEDF);
    // Dropped again, since that sprite has finished.
    send_rom(16'h1111);
    // Flipped, negative pitch, fully clipped on the left, top bank and both
    // zooms at their maximum; the address walk wraps below zero.
    send_entry(16'h0200, 16'h0000, 16'h0180, 16'h0000, 16'h0300, 16'h03FF);
    send_rom(16'hFFFF);
    send_rom(16'h0000);
    send_rom(16'hF123);
    // A sprite at the right-hand extreme, replaced half way by a new entry.
    send_entry(16'h3010, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'h0FFF, 16'h0021);
    send_rom(16'h2345);
    send_entry(16'h0100, 16'h00C0, 16'h0000, 16'h8000, 16'h01AA, 16'h0010);
    send_rom(16'h789F);

    // Random part, split over several x_offset settings with the extremes.
    phase_origin[0] = 9'd0;
    phase_origin[1] = 9'd511;
    phase_origin[2] = 9'($urandom_range(1, 510));
    phase_origin[3] = ORIGIN_RESET;
    for (ph = 0; ph < PHASES; ph++) begin
      // The sender pauses here until every expected result has come.
      wait_idle();
      write_origin(phase_origin[ph]);
      // In the first phase the receiver holds off for a long stretch while
      // the long row keeps requests coming back to back; the last phase has
      // no idling.
      steady   = (ph == 0 || ph == PHASES - 1);
      hold_req = (ph == 0);
      if (ph == 0)
        send_long_row();
      sent_here = 0;
      while (sent_here < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 99) < 8) begin
          // Stray ROM word, which may or may not find a sprite in progress.
          send_rom(16'($urandom));
          sent_here++;
        end else begin
          send_random_sprite();
          n = $urandom_range(1, 8);
          repeat (n) send_rom(random_rom_word());
          sent_here += n + 1;
        end
      end
      steady = 1'b0;
    end

    wait_idle();
    $display("Covered %0d requests (%0d sprite entries, %0d ROM words), %0d results checked,",
             requests_sent, entries_sent, words_sent, results_checked);
    $display("over %0d x offset settings with a long result stall and a row overrun.",
             settings_used);
    if (fail_total == 0 && pending_total == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
